### hw/rtl/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types and constants of the segment allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  localparam int DEF_MAX_SEGMENTS = 32;
  localparam int SIZE_W   = 21;
  localparam int AMOUNT_W = 16;
  localparam int OWNER_W  = 8;
  localparam int SLOT_W   = 5;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  localparam logic [1:0] FIT_FIRST = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_OWNER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic                free;
    logic [OWNER_W-1:0]  owner;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_APPEND,
    DP_SCAN_RD,
    DP_ALLOC_EV,
    DP_FREE_EV,
    DP_SET_NOFIT,
    DP_SET_FULL,
    DP_SET_OWNER,
    DP_SHIFT_INIT,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_SPLIT_REM,
    DP_ALLOC_WR,
    DP_CMP_INIT,
    DP_CMP_EV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cmp_end;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  scan_done;
    logic  found;
    logic  rem_zero;
    logic  full;
    logic  shift_done;
    logic  cmp_done;
  } dp_sts_t;

endpackage

### hw/rtl/fpsa_ram.sv
// ----------------------------------------------------------------------------
// fpsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fpsa_datapath.sv
// ----------------------------------------------------------------------------
// fpsa_datapath
// Segment table, scan registers and result registers of the allocator.
// ----------------------------------------------------------------------------
module fpsa_datapath #(
  parameter int MAX_SEGMENTS = fpsa_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpsa_pkg::dp_cmd_t              cmd,
  output fpsa_pkg::dp_sts_t              sts,
  input  logic [1:0]                     func,
  input  logic [fpsa_pkg::AMOUNT_W-1:0]  amount,
  input  logic [fpsa_pkg::OWNER_W-1:0]   owner_id,
  input  logic [1:0]                     fit_method,
  output logic [1:0]                     status,
  output logic [fpsa_pkg::SLOT_W-1:0]    slot_index,
  output logic [fpsa_pkg::SIZE_W-1:0]    remainder_size
);
  import fpsa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  func_t               func_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic [OWNER_W-1:0]  owner_r;
  logic [1:0]          method_r;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       wp;
  logic [IW-1:0]       sel;
  logic [SIZE_W-1:0]   sel_size;
  logic                found;
  logic                prev_free;
  logic [SIZE_W-1:0]   prev_size;
  logic [IW-1:0]       dest;
  logic                dest_ok;
  logic [SIZE_W-1:0]   dest_size;
  status_t             res_status;
  logic [IW-1:0]       res_slot;
  logic [SIZE_W-1:0]   res_rem;

  logic                we;
  logic [IW-1:0]       waddr;
  entry_t              wdata;
  logic [IW-1:0]       raddr;
  entry_t              rdata;

  entry_t              cur;
  logic                is_k;
  logic                fits;
  logic                take;
  logic                merge;
  logic [SIZE_W:0]     sum_w;
  logic [SIZE_W-1:0]   sum_sat;
  logic [SIZE_W-1:0]   rem;
  logic [CW-1:0]       wp_m1;
  logic [CW-1:0]       sel_p1;

  fpsa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cur = rdata;
    is_k = (idx[IW-1:0] == sel) && (idx < count);
    if (is_k) begin
      cur.free  = 1'b1;
      cur.owner = '0;
    end
    fits = rdata.free && (rdata.size >= SIZE_W'(amount_r));
    if (method_r == FIT_FIRST) begin
      take = fits && !found;
    end else if (method_r == FIT_BEST) begin
      take = fits && (!found || rdata.size < sel_size);
    end else begin
      take = fits && (!found || rdata.size > sel_size);
    end
    wp_m1   = wp - CW'(1);
    sel_p1  = CW'(sel) + CW'(1);
    merge   = cur.free && (wp != '0) && prev_free;
    sum_w   = {1'b0, prev_size} + {1'b0, cur.size};
    sum_sat = sum_w[SIZE_W] ? '1 : sum_w[SIZE_W-1:0];
    rem     = sel_size - SIZE_W'(amount_r);
  end

  // table write and read port
  always_comb begin
    we    = 1'b0;
    waddr = sel;
    wdata = '0;
    raddr = idx[IW-1:0];
    unique case (cmd.op)
      DP_APPEND: begin
        we    = (count != MAX_CNT);
        waddr = count[IW-1:0];
        wdata = '{free: 1'b1, owner: '0, size: SIZE_W'(amount_r)};
      end
      DP_SHIFT_RD: begin
        raddr = wp_m1[IW-1:0];
      end
      DP_SHIFT_WR: begin
        we    = 1'b1;
        waddr = wp[IW-1:0];
        wdata = rdata;
      end
      DP_SPLIT_REM: begin
        we    = 1'b1;
        waddr = sel_p1[IW-1:0];
        wdata = '{free: 1'b1, owner: '0, size: rem};
      end
      DP_ALLOC_WR: begin
        we    = 1'b1;
        waddr = sel;
        wdata = '{free: 1'b0, owner: owner_r, size: SIZE_W'(amount_r)};
      end
      DP_CMP_EV: begin
        we = 1'b1;
        if (merge) begin
          waddr = wp_m1[IW-1:0];
          wdata = '{free: 1'b1, owner: '0, size: sum_sat};
        end else begin
          waddr = wp[IW-1:0];
          wdata = cur;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.op)
        DP_LOAD: begin
          func_r     <= func_t'(func);
          amount_r   <= amount;
          owner_r    <= owner_id;
          method_r   <= fit_method;
          idx        <= '0;
          found      <= 1'b0;
          sel        <= '0;
          sel_size   <= '0;
          res_status <= ST_OK;
          res_slot   <= '0;
          res_rem    <= '0;
        end
        DP_APPEND: begin
          if (count == MAX_CNT) begin
            res_status <= ST_FULL;
          end else begin
            res_slot <= count[IW-1:0];
            count    <= count + CW'(1);
          end
        end
        DP_ALLOC_EV: begin
          if (take) begin
            sel      <= idx[IW-1:0];
            sel_size <= rdata.size;
            found    <= 1'b1;
          end
          idx <= idx + CW'(1);
        end
        DP_FREE_EV: begin
          if (!found && !rdata.free && rdata.owner == owner_r) begin
            sel   <= idx[IW-1:0];
            found <= 1'b1;
          end
          idx <= idx + CW'(1);
        end
        DP_SET_NOFIT: res_status <= ST_NOFIT;
        DP_SET_FULL:  res_status <= ST_FULL;
        DP_SET_OWNER: res_status <= ST_OWNER;
        DP_SHIFT_INIT: begin
          wp <= count;
        end
        DP_SHIFT_WR: begin
          wp <= wp_m1;
        end
        DP_SPLIT_REM: begin
          count <= count + CW'(1);
        end
        DP_ALLOC_WR: begin
          res_slot <= sel;
          res_rem  <= rem;
        end
        DP_CMP_INIT: begin
          idx       <= '0;
          wp        <= '0;
          prev_free <= 1'b0;
          prev_size <= '0;
          dest      <= '0;
          dest_ok   <= 1'b0;
          dest_size <= '0;
        end
        DP_CMP_EV: begin
          if (merge) begin
            prev_size <= sum_sat;
            if (is_k || (dest_ok && CW'(dest) == wp_m1)) begin
              dest      <= wp_m1[IW-1:0];
              dest_size <= sum_sat;
            end
          end else begin
            prev_free <= cur.free;
            prev_size <= cur.size;
            if (is_k) begin
              dest      <= wp[IW-1:0];
              dest_size <= cur.size;
            end
            wp <= wp + CW'(1);
          end
          if (is_k) begin
            dest_ok <= 1'b1;
          end
          idx <= idx + CW'(1);
        end
        default: begin
        end
      endcase
      if (cmd.cmp_end) begin
        count    <= wp;
        res_slot <= dest;
        res_rem  <= dest_size;
      end
      if (cmd.publish) begin
        status         <= res_status;
        slot_index     <= SLOT_W'(res_slot);
        remainder_size <= res_rem;
      end
    end
  end

  always_comb begin
    sts.func       = func_r;
    sts.found      = found;
    sts.scan_done  = (idx == count) ||
                     (found && (func_r == FUNC_FREE || method_r == FIT_FIRST));
    sts.rem_zero   = (rem == '0);
    sts.full       = (count == MAX_CNT);
    sts.shift_done = (wp <= sel_p1);
    sts.cmp_done   = (idx == count);
  end

endmodule

### hw/rtl/fpsa_ctrl.sv
// ----------------------------------------------------------------------------
// fpsa_ctrl
// Sequencer of the allocator: scan, shift, split and compaction passes.
// ----------------------------------------------------------------------------
module fpsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fpsa_pkg::dp_cmd_t cmd,
  input  fpsa_pkg::dp_sts_t sts
);
  import fpsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_ALLOC_DEC, S_SHIFT_RD,
    S_SHIFT_WR, S_SPLIT, S_ALLOC_WR, S_FREE_DEC, S_CMP_RD, S_CMP_EV, S_DONE
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next  = state;
    cmd.op      = DP_NOP;
    cmd.cmp_end = 1'b0;
    cmd.publish = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.func)
          FUNC_APPEND: begin
            cmd.op     = DP_APPEND;
            state_next = S_DONE;
          end
          FUNC_ALLOC, FUNC_FREE: state_next = S_SCAN_RD;
          default:               state_next = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        if (sts.scan_done) begin
          state_next = (sts.func == FUNC_ALLOC) ? S_ALLOC_DEC : S_FREE_DEC;
        end else begin
          cmd.op     = DP_SCAN_RD;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.op     = (sts.func == FUNC_ALLOC) ? DP_ALLOC_EV : DP_FREE_EV;
        state_next = S_SCAN_RD;
      end
      S_ALLOC_DEC: begin
        if (!sts.found) begin
          cmd.op     = DP_SET_NOFIT;
          state_next = S_DONE;
        end else if (sts.rem_zero) begin
          state_next = S_ALLOC_WR;
        end else if (sts.full) begin
          cmd.op     = DP_SET_FULL;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_SHIFT_INIT;
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_done) begin
          state_next = S_SPLIT;
        end else begin
          cmd.op     = DP_SHIFT_RD;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.op     = DP_SHIFT_WR;
        state_next = S_SHIFT_RD;
      end
      S_SPLIT: begin
        cmd.op     = DP_SPLIT_REM;
        state_next = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.op     = DP_ALLOC_WR;
        state_next = S_DONE;
      end
      S_FREE_DEC: begin
        if (!sts.found) begin
          cmd.op     = DP_SET_OWNER;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_CMP_INIT;
          state_next = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        if (sts.cmp_done) begin
          cmd.cmp_end = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.op     = DP_SCAN_RD;
          state_next = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        cmd.op     = DP_CMP_EV;
        state_next = S_CMP_RD;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/fit_policy_segment_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_segment_allocator
// Segment table allocator with first, best and worst fit and merge on free.
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall) carries one operation per
//   transaction: append a free segment, allocate by fit policy, or free by
//   owner. response channel (rsp_valid / rsp_stall) returns exactly one
//   transaction per request: status, slot index and remainder size.
//   first fit and free stop their scan at the match; an allocate with a
//   split moves the entries after the chosen slot up by one. every step of
//   a scan, a shift or the compaction pass issues the table read for an
//   entry and then uses the registered read data.
//   one operation is in flight at a time, so a new request is taken only
//   once the previous operation has finished.
//   req_stall is high while an operation is in progress; a finished
//   response sits in the output register, and the next request is taken
//   while it waits. if the receiver stalls, the block holds its next
//   result until the output register frees up.
//   reset (rst, synchronous) empties the table; table contents are not
//   cleared, entries past the fill count are never read.
// ----------------------------------------------------------------------------
module fit_policy_segment_allocator #(
  parameter int MAX_SEGMENTS = fpsa_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    func,
  input  logic [fpsa_pkg::AMOUNT_W-1:0] amount,
  input  logic [fpsa_pkg::OWNER_W-1:0]  owner_id,
  input  logic [1:0]                    fit_method,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [fpsa_pkg::SLOT_W-1:0]   slot_index,
  output logic [fpsa_pkg::SIZE_W-1:0]   remainder_size
);
  import fpsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: decides every step of the operation
  fpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table memory, scan state and the response register
  fpsa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .func           (func),
    .amount         (amount),
    .owner_id       (owner_id),
    .fit_method     (fit_method),
    .status         (status),
    .slot_index     (slot_index),
    .remainder_size (remainder_size)
  );

endmodule

### tb/segment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_checker
// Watches both channels, predicts every response of the segment allocator
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module segment_checker
  import fpsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  logic [1:0]          func,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic [OWNER_W-1:0]  owner_id,
  input  logic [1:0]          fit_method,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  logic [1:0]          status,
  input  logic [SLOT_W-1:0]   slot_index,
  input  logic [SIZE_W-1:0]   remainder_size,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [1:0]        st;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] rem;
  } answer_t;

  localparam int NSEG = DEF_MAX_SEGMENTS;

  entry_t  table_q [NSEG];
  int      fill;
  answer_t answers [$];

  function automatic answer_t predict_answer(logic [1:0] f, logic [AMOUNT_W-1:0] amt,
                                             logic [OWNER_W-1:0] own, logic [1:0] fit);
    answer_t a;
    int sel, k, w, dest;
    bit found;
    logic [SIZE_W:0] sum;
    logic [SIZE_W-1:0] rem;
    a = '0;
    case (func_t'(f))
      FUNC_APPEND: begin
        if (fill >= NSEG) a.st = ST_FULL;
        else begin
          table_q[fill] = '{free: 1'b1, owner: '0, size: SIZE_W'(amt)};
          a.slot = SLOT_W'(fill);
          fill++;
        end
      end
      FUNC_ALLOC: begin
        found = 0; sel = 0;
        for (int i = 0; i < fill; i++) begin
          if (!table_q[i].free || table_q[i].size < amt) continue;
          if (fit == FIT_FIRST) begin
            if (!found) begin sel = i; found = 1; end
          end else if (fit == FIT_BEST) begin
            if (!found || table_q[i].size < table_q[sel].size) begin sel = i; found = 1; end
          end else begin
            if (!found || table_q[i].size > table_q[sel].size) begin sel = i; found = 1; end
          end
        end
        if (!found) a.st = ST_NOFIT;
        else begin
          rem = table_q[sel].size - SIZE_W'(amt);
          if (rem != 0 && fill >= NSEG) a.st = ST_FULL;
          else begin
            if (rem != 0) begin
              for (int i = fill; i > sel + 1; i--) table_q[i] = table_q[i-1];
              table_q[sel+1] = '{free: 1'b1, owner: '0, size: rem};
              fill++;
              table_q[sel].size = SIZE_W'(amt);
            end
            table_q[sel].free = 1'b0;
            table_q[sel].owner = own;
            a.slot = SLOT_W'(sel);
            a.rem = rem;
          end
        end
      end
      FUNC_FREE: begin
        found = 0; k = 0;
        for (int i = 0; i < fill; i++)
          if (!found && !table_q[i].free && table_q[i].owner == own) begin
            k = i; found = 1;
          end
        if (!found) a.st = ST_OWNER;
        else begin
          table_q[k].free = 1'b1;
          table_q[k].owner = '0;
          w = 0; dest = 0;
          for (int i = 0; i < fill; i++) begin
            if (table_q[i].free && w > 0 && table_q[w-1].free) begin
              sum = table_q[w-1].size + table_q[i].size;
              table_q[w-1].size = sum[SIZE_W] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
              if (i == k) dest = w - 1;
            end else begin
              table_q[w] = table_q[i];
              if (i == k) dest = w;
              w++;
            end
          end
          fill = w;
          a.slot = SLOT_W'(dest);
          a.rem = table_q[dest].size;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  assign pending = answers.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      fill = 0;
      fail_count <= 0;
      answers.delete();
    end else begin
      if (req_valid && !req_stall)
        answers.push_back(predict_answer(func, amount, owner_id, fit_method));
      if (rsp_valid && !rsp_stall) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected response status=%0d slot=%0d rem=%0d",
                   $time, status, slot_index, remainder_size);
          fail_count <= fail_count + 1;
        end else begin
          want = answers.pop_front();
          if (want.st !== status || want.slot !== slot_index || want.rem !== remainder_size) begin
            $display("%0t: mismatch expected status=%0d slot=%0d rem=%0d, actual status=%0d slot=%0d rem=%0d",
                     $time, want.st, want.slot, want.rem, status, slot_index, remainder_size);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives append, allocate and free transactions into the segment allocator
// with bursty requests and a stalling receiver, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import fpsa_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [1:0]          func = '0;
  logic [AMOUNT_W-1:0] amount = '0;
  logic [OWNER_W-1:0]  owner_id = '0;
  logic [1:0]          fit_method = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot_index;
  logic [SIZE_W-1:0]   remainder_size;
  int                  fail_count;
  int                  pending;

  // idle-cycle watchdog
  localparam int IDLE_LIMIT = 5000;
  int idle_cycles = 0;
  int stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fit_policy_segment_allocator dut (.*);

  segment_checker chk (.*);

  // receiver stall pattern: switches between no stall, light and heavy stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      default: rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog counts cycles without any accepted transaction
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // drive one transaction and wait until it is accepted
  task automatic send_op(logic [1:0] f, logic [AMOUNT_W-1:0] amt,
                         logic [OWNER_W-1:0] own, logic [1:0] fit);
    req_valid <= 1'b1;
    func <= f;
    amount <= amt;
    owner_id <= own;
    fit_method <= fit;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic drop_valid_gap(int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      func <= 2'($urandom);
      amount <= 16'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // random operation mix weighted toward well-formed allocate/free traffic
  task automatic random_op();
    int r;
    logic [AMOUNT_W-1:0] amt;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) amt = 16'($urandom);
    else if ($urandom_range(0, 19) == 0) amt = 16'hFFFF;
    else amt = 16'($urandom_range(0, 300));
    // few owners so frees mostly hit
    if (r < 20) send_op(FUNC_APPEND, amt, 8'($urandom), 2'($urandom));
    else if (r < 58) send_op(FUNC_ALLOC, amt, 8'($urandom_range(0, 7)), 2'($urandom));
    else if (r < 94) send_op(FUNC_FREE, 16'($urandom),
                             ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 7)),
                             2'($urandom));
    else send_op(FUNC_RSVD, 16'($urandom), 8'($urandom), 2'($urandom));
  endtask

  initial begin
    int burst;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-table refusals, extremes, every fit method, reserved code
    send_op(FUNC_ALLOC, 16'd1, 8'd1, FIT_FIRST);
    send_op(FUNC_FREE, 16'd0, 8'd1, 2'd0);
    send_op(FUNC_APPEND, 16'hFFFF, 8'hFF, 2'd3);
    send_op(FUNC_APPEND, 16'd1, 8'd0, 2'd0);
    send_op(FUNC_APPEND, 16'd100, 8'd0, 2'd0);
    send_op(FUNC_APPEND, 16'd50, 8'd0, 2'd0);
    send_op(FUNC_ALLOC, 16'd40, 8'd10, FIT_FIRST);
    send_op(FUNC_ALLOC, 16'd40, 8'd11, FIT_BEST);
    send_op(FUNC_ALLOC, 16'd40, 8'd12, 2'd3);
    send_op(FUNC_ALLOC, 16'd0, 8'd13, 2'd0);
    send_op(FUNC_ALLOC, 16'd1, 8'hFF, FIT_BEST);
    send_op(FUNC_ALLOC, 16'hFFFF, 8'd14, FIT_FIRST);
    send_op(FUNC_FREE, 16'd0, 8'd99, 2'd0);
    send_op(FUNC_FREE, 16'd0, 8'd10, 2'd0);
    send_op(FUNC_FREE, 16'd0, 8'd13, 2'd0);
    send_op(FUNC_RSVD, 16'hFFFF, 8'hFF, 2'd3);
    // large merge: many max-size appends merged into one segment on a free
    for (int i = 0; i < 34; i++) send_op(FUNC_APPEND, 16'hFFFF, 8'd0, 2'd0);
    send_op(FUNC_ALLOC, 16'd5, 8'd20, FIT_FIRST);
    send_op(FUNC_ALLOC, 16'hFFFF, 8'd21, FIT_BEST);
    send_op(FUNC_FREE, 16'd0, 8'd21, 2'd0);
    send_op(FUNC_FREE, 16'd0, 8'hFF, 2'd0);

    // random part in bursts with gaps
    for (int n = 0; n < 1700; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        random_op();
        n++;
      end
      drop_valid_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
hw/rtl/fpsa_pkg.sv
hw/rtl/fpsa_ram.sv
hw/rtl/fpsa_datapath.sv
hw/rtl/fpsa_ctrl.sv
hw/rtl/fit_policy_segment_allocator.sv
tb/segment_checker.sv
tb/tb.sv
